// ----- rtl/vrs_pkg.sv -----
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared types, constants and arithmetic helpers for the vertex rotate and
// scale pipeline.
// ----------------------------------------------------------------------------
package vrs_pkg;

    // Fixed-point constants.
    localparam int FRAC_BITS   = 13;
    localparam int SCALE_SHIFT = 3;
    localparam int POS_W       = 16;
    localparam int COEF_W      = 15;
    localparam int GAIN_W      = 16;
    localparam int ACC_W       = 32;
    // Width of a value after the Q13 shift of a 32-bit sum.
    localparam int ROT_W       = ACC_W - FRAC_BITS;
    // Width of a coefficient as presented to the multipliers.
    localparam int MUL_W       = 16;
    localparam int PROD_W      = ROT_W + MUL_W;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIN_X      = 3'd0,
        REG_COS_X      = 3'd1,
        REG_SIN_Y      = 3'd2,
        REG_COS_Y      = 3'd3,
        REG_SIN_Z      = 3'd4,
        REG_COS_Z      = 3'd5,
        REG_SCALE_GAIN = 3'd6
    } cfg_idx_t;

    // Coefficients as the datapath uses them, with negated sines ready.
    typedef struct packed {
        logic signed [MUL_W-1:0] sin_x;
        logic signed [MUL_W-1:0] cos_x;
        logic signed [MUL_W-1:0] nsin_x;
        logic signed [MUL_W-1:0] sin_y;
        logic signed [MUL_W-1:0] cos_y;
        logic signed [MUL_W-1:0] nsin_y;
        logic signed [MUL_W-1:0] sin_z;
        logic signed [MUL_W-1:0] cos_z;
        logic signed [MUL_W-1:0] nsin_z;
        logic signed [MUL_W-1:0] gain;
    } coef_t;

    // Normal vector carried alongside the position.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } norm_t;

    // Product of a rotated value and a coefficient, wrapped to 32 bits.
    function automatic logic signed [ACC_W-1:0] mul_wrap(
        input logic signed [ROT_W-1:0] a,
        input logic signed [MUL_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return p[ACC_W-1:0];
    endfunction

    // Arithmetic shift right by the fraction width of a 32-bit sum.
    function automatic logic signed [ROT_W-1:0] asr_frac(
        input logic signed [ACC_W-1:0] s
    );
        return s[ACC_W-1:FRAC_BITS];
    endfunction

    // Sign extension of an input coordinate to the rotated width.
    function automatic logic signed [ROT_W-1:0] ext_pos(
        input logic signed [POS_W-1:0] p
    );
        return {{(ROT_W-POS_W){p[POS_W-1]}}, p};
    endfunction

endpackage

// ----- rtl/vrs_cfg.sv -----
// ----------------------------------------------------------------------------
// vrs_cfg
// Configuration register file: decodes writes, holds the sine, cosine and
// gain values and presents them sign-extended with negated sines.
// ----------------------------------------------------------------------------
module vrs_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vrs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vrs_pkg::CFG_DATA_W-1:0]       cfg_data,
    output vrs_pkg::coef_t                       coef
);

    logic signed [vrs_pkg::COEF_W-1:0] sin_x_reg, cos_x_reg;
    logic signed [vrs_pkg::COEF_W-1:0] sin_y_reg, cos_y_reg;
    logic signed [vrs_pkg::COEF_W-1:0] sin_z_reg, cos_z_reg;
    logic signed [vrs_pkg::GAIN_W-1:0] gain_reg;
    logic signed [vrs_pkg::COEF_W-1:0] wr_coef;

    // The angle registers keep the low 15 bits of the written word.
    assign wr_coef = cfg_data[vrs_pkg::COEF_W-1:0];

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_x_reg <= '0;
            cos_x_reg <= 15'sd8192;
            sin_y_reg <= '0;
            cos_y_reg <= 15'sd8192;
            sin_z_reg <= '0;
            cos_z_reg <= 15'sd8192;
            gain_reg  <= 16'sd1;
        end
        else if (cfg_we)
        begin
            unique case (vrs_pkg::cfg_idx_t'(cfg_index))
                vrs_pkg::REG_SIN_X:      sin_x_reg <= wr_coef;
                vrs_pkg::REG_COS_X:      cos_x_reg <= wr_coef;
                vrs_pkg::REG_SIN_Y:      sin_y_reg <= wr_coef;
                vrs_pkg::REG_COS_Y:      cos_y_reg <= wr_coef;
                vrs_pkg::REG_SIN_Z:      sin_z_reg <= wr_coef;
                vrs_pkg::REG_COS_Z:      cos_z_reg <= wr_coef;
                vrs_pkg::REG_SCALE_GAIN: gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sign-extend to the multiplier width; the negated sine of -16384 still fits.
    always_comb
    begin
        coef.sin_x  = {sin_x_reg[vrs_pkg::COEF_W-1], sin_x_reg};
        coef.cos_x  = {cos_x_reg[vrs_pkg::COEF_W-1], cos_x_reg};
        coef.nsin_x = -coef.sin_x;
        coef.sin_y  = {sin_y_reg[vrs_pkg::COEF_W-1], sin_y_reg};
        coef.cos_y  = {cos_y_reg[vrs_pkg::COEF_W-1], cos_y_reg};
        coef.nsin_y = -coef.sin_y;
        coef.sin_z  = {sin_z_reg[vrs_pkg::COEF_W-1], sin_z_reg};
        coef.cos_z  = {cos_z_reg[vrs_pkg::COEF_W-1], cos_z_reg};
        coef.nsin_z = -coef.sin_z;
        coef.gain   = gain_reg;
    end

endmodule

// ----- rtl/vertex_rotate_scale.sv -----
// An accepted beat passes through five register stages, A to E, to the output.
// Throughput: one vertex per cycle while out_stall is low. Stages A to D each
// hold one multiply rank, B to D after the add and shift of the previous rank;
// E adds the shifted scale product. Reset clears all stage valid bits and loads
// the registers with identity rotation (sine 0, cosine 8192) and gain 1.
// ----------------------------------------------------------------------------
// vertex_rotate_scale
// Rotates a vertex position about X, Y and Z with Q13 coefficients, then
// scales it as p + ((p * gain) >> 3). The normal travels through unchanged.
// ----------------------------------------------------------------------------
module vertex_rotate_scale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [vrs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vrs_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vrs_pkg::POS_W-1:0]      pos_x,
    input  logic signed [vrs_pkg::POS_W-1:0]      pos_y,
    input  logic signed [vrs_pkg::POS_W-1:0]      pos_z,
    input  logic signed [vrs_pkg::POS_W-1:0]      norm_in_x,
    input  logic signed [vrs_pkg::POS_W-1:0]      norm_in_y,
    input  logic signed [vrs_pkg::POS_W-1:0]      norm_in_z,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vrs_pkg::ACC_W-1:0]      out_x,
    output logic signed [vrs_pkg::ACC_W-1:0]      out_y,
    output logic signed [vrs_pkg::ACC_W-1:0]      out_z,
    output logic signed [vrs_pkg::POS_W-1:0]      norm_out_x,
    output logic signed [vrs_pkg::POS_W-1:0]      norm_out_y,
    output logic signed [vrs_pkg::POS_W-1:0]      norm_out_z
);

    vrs_pkg::coef_t coef;

    // Stage valid bits and advance conditions.
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    // Stage A: products of the X rotation.
    logic signed [vrs_pkg::ACC_W-1:0] a_p_reg [4];
    logic signed [vrs_pkg::POS_W-1:0] a_x_reg;
    vrs_pkg::norm_t                   a_nrm_reg;

    // Stage B: products of the Y rotation.
    logic signed [vrs_pkg::ROT_W-1:0] b_y1_next, b_z1_next;
    logic signed [vrs_pkg::ROT_W-1:0] b_x_next;
    logic signed [vrs_pkg::ACC_W-1:0] b_p_reg [4];
    logic signed [vrs_pkg::ROT_W-1:0] b_y1_reg;
    vrs_pkg::norm_t                   b_nrm_reg;

    // Stage C: products of the Z rotation.
    logic signed [vrs_pkg::ROT_W-1:0] c_x2_next, c_z2_next;
    logic signed [vrs_pkg::ACC_W-1:0] c_p_reg [4];
    logic signed [vrs_pkg::ROT_W-1:0] c_z2_reg;
    vrs_pkg::norm_t                   c_nrm_reg;

    // Stage D: scale products.
    logic signed [vrs_pkg::ROT_W-1:0] d_x3_next, d_y3_next;
    logic signed [vrs_pkg::ACC_W-1:0] d_p_reg [3];
    logic signed [vrs_pkg::ROT_W-1:0] d_pos_reg [3];
    vrs_pkg::norm_t                   d_nrm_reg;

    // Stage E: output register.
    logic signed [vrs_pkg::ACC_W-1:0] e_out_next [3];
    logic signed [vrs_pkg::ACC_W-1:0] e_out_reg [3];
    vrs_pkg::norm_t                   e_nrm_reg;

    vrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // A stage takes a new beat when it is empty or its content moves on.
    assign rdy_e    = !vld_e_reg || !out_stall;
    assign rdy_d    = !vld_d_reg || rdy_e;
    assign rdy_c    = !vld_c_reg || rdy_d;
    assign rdy_b    = !vld_b_reg || rdy_c;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_stall = !rdy_a;

    // Valid bits follow the beats down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                vld_a_reg <= in_valid;
            if (rdy_b)
                vld_b_reg <= vld_a_reg;
            if (rdy_c)
                vld_c_reg <= vld_b_reg;
            if (rdy_d)
                vld_d_reg <= vld_c_reg;
            if (rdy_e)
                vld_e_reg <= vld_d_reg;
        end
    end

    // Stage A: rotation about X, products of the input position.
    always_ff @(posedge clk)
    begin
        if (in_valid && rdy_a)
        begin
            a_p_reg[0] <= vrs_pkg::mul_wrap(vrs_pkg::ext_pos(pos_y), coef.cos_x);
            a_p_reg[1] <= vrs_pkg::mul_wrap(vrs_pkg::ext_pos(pos_z), coef.nsin_x);
            a_p_reg[2] <= vrs_pkg::mul_wrap(vrs_pkg::ext_pos(pos_y), coef.sin_x);
            a_p_reg[3] <= vrs_pkg::mul_wrap(vrs_pkg::ext_pos(pos_z), coef.cos_x);
            a_x_reg    <= pos_x;
            a_nrm_reg  <= '{x: norm_in_x, y: norm_in_y, z: norm_in_z};
        end
    end

    // Stage B: finish the X rotation, then multiply for the Y rotation.
    assign b_y1_next = vrs_pkg::asr_frac(a_p_reg[0] + a_p_reg[1]);
    assign b_z1_next = vrs_pkg::asr_frac(a_p_reg[2] + a_p_reg[3]);
    assign b_x_next  = vrs_pkg::ext_pos(a_x_reg);

    always_ff @(posedge clk)
    begin
        if (vld_a_reg && rdy_b)
        begin
            b_p_reg[0] <= vrs_pkg::mul_wrap(b_z1_next, coef.sin_y);
            b_p_reg[1] <= vrs_pkg::mul_wrap(b_x_next, coef.cos_y);
            b_p_reg[2] <= vrs_pkg::mul_wrap(b_z1_next, coef.cos_y);
            b_p_reg[3] <= vrs_pkg::mul_wrap(b_x_next, coef.nsin_y);
            b_y1_reg   <= b_y1_next;
            b_nrm_reg  <= a_nrm_reg;
        end
    end

    // Stage C: finish the Y rotation, then multiply for the Z rotation.
    assign c_x2_next = vrs_pkg::asr_frac(b_p_reg[0] + b_p_reg[1]);
    assign c_z2_next = vrs_pkg::asr_frac(b_p_reg[2] + b_p_reg[3]);

    always_ff @(posedge clk)
    begin
        if (vld_b_reg && rdy_c)
        begin
            c_p_reg[0] <= vrs_pkg::mul_wrap(c_x2_next, coef.cos_z);
            c_p_reg[1] <= vrs_pkg::mul_wrap(b_y1_reg, coef.nsin_z);
            c_p_reg[2] <= vrs_pkg::mul_wrap(c_x2_next, coef.sin_z);
            c_p_reg[3] <= vrs_pkg::mul_wrap(b_y1_reg, coef.cos_z);
            c_z2_reg   <= c_z2_next;
            c_nrm_reg  <= b_nrm_reg;
        end
    end

    // Stage D: finish the Z rotation, then multiply by the gain.
    assign d_x3_next = vrs_pkg::asr_frac(c_p_reg[0] + c_p_reg[1]);
    assign d_y3_next = vrs_pkg::asr_frac(c_p_reg[2] + c_p_reg[3]);

    always_ff @(posedge clk)
    begin
        if (vld_c_reg && rdy_d)
        begin
            d_p_reg[0]   <= vrs_pkg::mul_wrap(d_x3_next, coef.gain);
            d_p_reg[1]   <= vrs_pkg::mul_wrap(d_y3_next, coef.gain);
            d_p_reg[2]   <= vrs_pkg::mul_wrap(c_z2_reg, coef.gain);
            d_pos_reg[0] <= d_x3_next;
            d_pos_reg[1] <= d_y3_next;
            d_pos_reg[2] <= c_z2_reg;
            d_nrm_reg    <= c_nrm_reg;
        end
    end

    // Stage E: add the shifted scale product back onto the position.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_out_next[i] =
                {{(vrs_pkg::ACC_W-vrs_pkg::ROT_W){d_pos_reg[i][vrs_pkg::ROT_W-1]}},
                 d_pos_reg[i]}
              + {{vrs_pkg::SCALE_SHIFT{d_p_reg[i][vrs_pkg::ACC_W-1]}},
                 d_p_reg[i][vrs_pkg::ACC_W-1:vrs_pkg::SCALE_SHIFT]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_d_reg && rdy_e)
        begin
            e_out_reg <= e_out_next;
            e_nrm_reg <= d_nrm_reg;
        end
    end

    // Output beat.
    assign out_valid  = vld_e_reg;
    assign out_x      = e_out_reg[0];
    assign out_y      = e_out_reg[1];
    assign out_z      = e_out_reg[2];
    assign norm_out_x = e_nrm_reg.x;
    assign norm_out_y = e_nrm_reg.y;
    assign norm_out_z = e_nrm_reg.z;

endmodule

// ----- dv/vertex_rotate_scale_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_rotate_scale_tb
// Streams vertices through the rotate and scale pipeline under several
// coefficient settings. These include identity, both coefficient extremes,
// values past the Q13 range, a write past the last register and random
// angles. Each output beat is checked against a cycle-free prediction of
// the rotated, scaled position and the passed-through normal. The input idles
// and the output stalls at random.
// ----------------------------------------------------------------------------
module vertex_rotate_scale_tb;
    import vrs_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 40;
    localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = 3'd7;
    localparam int PAST_END_NUM    = int'(IDX_PAST_END);
    localparam int GAIN_NUM        = int'(REG_SCALE_GAIN);

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        logic signed [POS_W-1:0] nz;
    } vertex_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        logic signed [POS_W-1:0] nz;
    } vertex_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic signed [POS_W-1:0] norm_in_x = '0;
    logic signed [POS_W-1:0] norm_in_y = '0;
    logic signed [POS_W-1:0] norm_in_z = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [ACC_W-1:0] out_x;
    logic signed [ACC_W-1:0] out_y;
    logic signed [ACC_W-1:0] out_z;
    logic signed [POS_W-1:0] norm_out_x;
    logic signed [POS_W-1:0] norm_out_y;
    logic signed [POS_W-1:0] norm_out_z;

    // Shadow copy of the coefficient registers, sign-extended to 32 bits.
    logic signed [ACC_W-1:0] coef_model [0:6];

    vertex_t        vertex_queue [$];
    vertex_result_t result_fifo [$];
    vertex_t        bus_vertex;
    int             burst_left;
    int             gap_left;
    int             stall_left;
    int             stall_mode;
    logic           stall_next;
    vertex_result_t want;
    int             out_beats = 0;
    int             error_count = 0;
    int             quiet_cycles = 0;

    vertex_rotate_scale uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .norm_in_x  (norm_in_x),
        .norm_in_y  (norm_in_y),
        .norm_in_z  (norm_in_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .norm_out_x (norm_out_x),
        .norm_out_y (norm_out_y),
        .norm_out_z (norm_out_z)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Q13 product sum of two pairs, wrapping at 32 bits, shifted arithmetically.
    function automatic logic signed [ACC_W-1:0] q13_dot(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] c,
        input logic signed [ACC_W-1:0] b,
        input logic signed [ACC_W-1:0] d
    );
        logic signed [ACC_W-1:0] sum;
        sum = a * c + b * d;
        return sum >>> FRAC_BITS;
    endfunction

    // Position scaling: p + ((p * gain) >> 3), wrapping at 32 bits.
    function automatic logic signed [ACC_W-1:0] apply_gain(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] prod;
        prod = p * coef_model[REG_SCALE_GAIN];
        return p + (prod >>> SCALE_SHIFT);
    endfunction

    // Rotation about X, then Y, then Z; the Z rotation also takes y1 from the X rotation.
    function automatic vertex_result_t predict_vertex(input vertex_t v);
        logic signed [ACC_W-1:0] y1, z1, x2, z2, x3, y3;
        vertex_result_t r;
        y1 = q13_dot(ACC_W'(v.py), coef_model[REG_COS_X],
                     ACC_W'(v.pz), -coef_model[REG_SIN_X]);
        z1 = q13_dot(ACC_W'(v.py), coef_model[REG_SIN_X],
                     ACC_W'(v.pz), coef_model[REG_COS_X]);
        x2 = q13_dot(z1, coef_model[REG_SIN_Y], ACC_W'(v.px), coef_model[REG_COS_Y]);
        z2 = q13_dot(z1, coef_model[REG_COS_Y], ACC_W'(v.px), -coef_model[REG_SIN_Y]);
        x3 = q13_dot(x2, coef_model[REG_COS_Z], y1, -coef_model[REG_SIN_Z]);
        y3 = q13_dot(x2, coef_model[REG_SIN_Z], y1, coef_model[REG_COS_Z]);
        r.x  = apply_gain(x3);
        r.y  = apply_gain(y3);
        r.z  = apply_gain(z2);
        r.nx = v.nx;
        r.ny = v.ny;
        r.nz = v.nz;
        return r;
    endfunction

    // Coordinates lean toward the extremes and small values around zero.
    function automatic logic signed [POS_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return POS_W'($urandom_range(0, 32)) - 16'sd16;
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(
        input string                   name,
        input logic signed [ACC_W-1:0] got,
        input logic signed [ACC_W-1:0] expected
    );
        if (got !== expected)
        begin
            report_error($sformatf("beat %0d %s: got %0d, expected %0d",
                out_beats, name, got, expected));
        end
    endtask

    // Returns once no vertex is queued, on the bus or in flight.
    task automatic wait_idle();
        while (vertex_queue.size() != 0 || in_valid || result_fifo.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Input driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                result_fifo.push_back(predict_vertex(bus_vertex));
            end
            if (in_valid && in_stall)
            begin
                // A stalled beat holds its payload.
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (vertex_queue.size() != 0)
            begin
                bus_vertex = vertex_queue.pop_front();
                pos_x     <= bus_vertex.px;
                pos_y     <= bus_vertex.py;
                pos_z     <= bus_vertex.pz;
                norm_in_x <= bus_vertex.nx;
                norm_in_y <= bus_vertex.ny;
                norm_in_z <= bus_vertex.nz;
                in_valid  <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20)
                                                           : $urandom_range(0, 3);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each accepted beat and drives a stall pattern
    // that switches among free-running, light, heavy and alternating stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            stall_mode = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_fifo.size() == 0)
                begin
                    report_error($sformatf("beat %0d arrived with no vertex outstanding",
                        out_beats));
                end
                else
                begin
                    want = result_fifo.pop_front();
                    check_field("out_x", out_x, want.x);
                    check_field("out_y", out_y, want.y);
                    check_field("out_z", out_z, want.z);
                    check_field("norm_out_x", ACC_W'(norm_out_x), ACC_W'(want.nx));
                    check_field("norm_out_y", ACC_W'(norm_out_y), ACC_W'(want.ny));
                    check_field("norm_out_z", ACC_W'(norm_out_z), ACC_W'(want.nz));
                end
                out_beats++;
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(4, 60);
            end
            stall_left--;
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 9) < 7);
                default: stall_next = stall_left[0];
            endcase
            out_stall <= stall_next;
        end
    end

    // Watchdog: ends the run after a long stretch with no beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed vertices, then one random batch per
    // coefficient setting.
    initial
    begin
        int                      phase;
        int                      i;
        logic signed [15:0]      reg_val [0:6];
        logic [CFG_DATA_W-1:0]   raw;

        // Register values after reset: identity rotation, gain of one.
        coef_model[REG_SIN_X]      = 0;
        coef_model[REG_COS_X]      = 8192;
        coef_model[REG_SIN_Y]      = 0;
        coef_model[REG_COS_Y]      = 8192;
        coef_model[REG_SIN_Z]      = 0;
        coef_model[REG_COS_Z]      = 8192;
        coef_model[REG_SCALE_GAIN] = 1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed vertices: zeros, corners, unit axes and bit patterns.
        vertex_queue.push_back('{0, 0, 0, 0, 0, 0});
        vertex_queue.push_back('{32767, 32767, 32767, 32767, 32767, 32767});
        vertex_queue.push_back('{-32768, -32768, -32768, -32768, -32768, -32768});
        vertex_queue.push_back('{32767, -32768, 32767, -32768, 32767, -32768});
        vertex_queue.push_back('{-32768, 32767, -32768, 32767, -32768, 32767});
        vertex_queue.push_back('{-1, -1, -1, -1, -1, -1});
        vertex_queue.push_back('{1, 0, 0, 0, 0, 1});
        vertex_queue.push_back('{0, 1, 0, 0, 1, 0});
        vertex_queue.push_back('{0, 0, 1, 1, 0, 0});
        vertex_queue.push_back('{-1, 7, -8, 8, -7, 1});
        vertex_queue.push_back('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        vertex_queue.push_back('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        vertex_queue.push_back('{-32768, 0, 32767, 0, -32768, 0});
        vertex_queue.push_back('{4096, -4096, 12345, -12345, 255, -256});

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase != 0)
            begin
                wait_idle();
                repeat (DRAIN_CYCLES) @(posedge clk);

                // Choose the setting: both coefficient extremes, values past
                // the Q13 range, then random angles and gains.
                for (i = 0; i < 7; i++)
                begin
                    case (phase)
                        1: reg_val[i] = (i == GAIN_NUM) ? 16'sh7FFF : 16'sd8192;
                        2: reg_val[i] = (i == GAIN_NUM) ? 16'sh8000 : -16'sd8192;
                        3:
                        begin
                            if (i == GAIN_NUM)
                                reg_val[i] = 16'sd0;
                            else
                                reg_val[i] = (i % 2 == 0) ? 16'sh3FFF : 16'sh4000;
                        end
                        default:
                        begin
                            if (i != GAIN_NUM)
                            begin
                                reg_val[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(0, 16384)) - 16'sd8192;
                            end
                            else
                            begin
                                case ($urandom_range(0, 5))
                                    0: reg_val[i] = -16'sd8;
                                    1: reg_val[i] = 16'sd1;
                                    2: reg_val[i] = 16'sh7FFF;
                                    3: reg_val[i] = 16'sh8000;
                                    default: reg_val[i] = 16'($urandom);
                                endcase
                            end
                        end
                    endcase
                end

                // Back-to-back register writes; every third phase also
                // writes past the last register, which must change nothing.
                for (i = 0; i <= PAST_END_NUM; i++)
                begin
                    if (i == PAST_END_NUM && phase % 3 != 1)
                        break;
                    raw = (i == PAST_END_NUM) ? CFG_DATA_W'($urandom) : reg_val[i];
                    if (i < GAIN_NUM)
                        raw[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
                    @(posedge clk);
                    cfg_we    <= 1'b1;
                    cfg_index <= CFG_IDX_W'(i);
                    cfg_data  <= raw;
                    if (i == GAIN_NUM)
                        coef_model[i] = ACC_W'($signed(raw));
                    else if (i < GAIN_NUM)
                        coef_model[i] = ACC_W'($signed(raw[COEF_W-1:0]));
                end
                @(posedge clk);
                cfg_we <= 1'b0;
                @(negedge clk);
            end

            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                vertex_queue.push_back('{random_coord(), random_coord(), random_coord(),
                                         random_coord(), random_coord(), random_coord()});
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
